### rtl/flwe_pkg.sv
package flwe_pkg;

  localparam int unsigned MaxWindow  = 16;
  localparam int unsigned LengthBits = 10;
  localparam int unsigned IdxW       = $clog2(MaxWindow);
  localparam int unsigned CntW       = $clog2(MaxWindow + 1);
  localparam int unsigned OffW       = 16;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned CfgW       = 5;
  localparam int unsigned StepW      = 4;
  localparam logic [CfgW-1:0] WinSizeReset = CfgW'(4);
  localparam logic [OffW-1:0] OffMax       = '1;

  typedef logic [LengthBits-1:0] len_t;
  typedef logic [IdxW-1:0]       idx_t;
  typedef logic [CntW-1:0]       cnt_t;
  typedef logic [StepW-1:0]      step_t;

  typedef enum logic [CmdW-1:0] {
    CMD_LEN = 2'd0,
    CMD_SET = 2'd1,
    CMD_CLR = 2'd2,
    CMD_END = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_REDUCE,
    OP_SET_REGION,
    OP_ZERO_OLDEST,
    OP_PROMOTE,
    OP_FILL,
    OP_SLIDE,
    OP_EMIT_INIT,
    OP_EMIT,
    OP_CLEAR
  } op_e;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_OLD_GE_K,
    C_CMD_LEN,
    C_CMD_END,
    C_FULL,
    C_NOT_FULL,
    C_EMIT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic last_fire;
    logic old_ge_k;
    logic cmd_len;
    logic cmd_end;
    logic full;
  } status_t;

endpackage

### rtl/flwe_in_if.sv
interface flwe_in_if;
  import flwe_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CmdW-1:0]       cmd;
  logic [LengthBits-1:0] factor_length;

  modport source (output valid, output cmd, output factor_length, input ready);
  modport sink   (input valid, input cmd, input factor_length, output ready);
endinterface

### rtl/flwe_out_if.sv
interface flwe_out_if;
  import flwe_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [LengthBits-1:0] element_length;
  logic                  second_pass;
  logic [OffW-1:0]       window_offset;
  logic                  last_of_window;

  modport source (output valid, output element_length, output second_pass,
                  output window_offset, output last_of_window, input ready);
  modport sink   (input valid, input element_length, input second_pass,
                  input window_offset, input last_of_window, output ready);
endinterface

### rtl/flwe_cfg_if.sv
interface flwe_cfg_if;
  import flwe_pkg::*;
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

### rtl/flwe_sequencer.sv
module flwe_sequencer
  import flwe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  localparam step_t StWait   = step_t'(0);
  localparam step_t StReduce = step_t'(1);
  localparam step_t StEnd    = step_t'(5);
  localparam step_t StLen    = step_t'(7);
  localparam step_t StSlide  = step_t'(9);
  localparam step_t StFill   = step_t'(10);
  localparam step_t StEmitIn = step_t'(12);
  localparam step_t StEmit   = step_t'(13);
  localparam step_t StClear  = step_t'(15);

  function automatic ctrl_t rom(input step_t s);
    ctrl_t c;
    c = '{op: OP_NOP, cond: C_ALWAYS, target: StWait};
    case (s)
      4'd0:  c = '{op: OP_LATCH,      cond: C_NO_ACCEPT, target: StWait};
      4'd1:  c = '{op: OP_REDUCE,     cond: C_OLD_GE_K,  target: StReduce};
      4'd2:  c = '{op: OP_NOP,        cond: C_CMD_LEN,   target: StLen};
      4'd3:  c = '{op: OP_NOP,        cond: C_CMD_END,   target: StEnd};
      4'd4:  c = '{op: OP_SET_REGION, cond: C_ALWAYS,    target: StWait};
      4'd5:  c = '{op: OP_ZERO_OLDEST, cond: C_FULL,     target: StClear};
      4'd6:  c = '{op: OP_NOP,        cond: C_ALWAYS,    target: StEmitIn};
      4'd7:  c = '{op: OP_PROMOTE,    cond: C_NEXT,      target: StWait};
      4'd8:  c = '{op: OP_NOP,        cond: C_NOT_FULL,  target: StFill};
      4'd9:  c = '{op: OP_SLIDE,      cond: C_ALWAYS,    target: StEmitIn};
      4'd10: c = '{op: OP_FILL,       cond: C_NEXT,      target: StWait};
      4'd11: c = '{op: OP_NOP,        cond: C_NOT_FULL,  target: StWait};
      4'd12: c = '{op: OP_EMIT_INIT,  cond: C_NEXT,      target: StWait};
      4'd13: c = '{op: OP_EMIT,       cond: C_EMIT_BUSY, target: StEmit};
      4'd14: c = '{op: OP_NOP,        cond: C_CMD_LEN,   target: StWait};
      4'd15: c = '{op: OP_CLEAR,      cond: C_ALWAYS,    target: StWait};
      default: c = '{op: OP_NOP, cond: C_ALWAYS, target: StWait};
    endcase
    return c;
  endfunction

  step_t step_q, step_d;
  ctrl_t ctrl;
  logic  taken;

  assign ctrl   = rom(step_q);
  assign ctrl_o = ctrl;

  always_comb begin
    case (ctrl.cond)
      C_NEXT:      taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_ACCEPT: taken = !status_i.in_fire;
      C_OLD_GE_K:  taken = status_i.old_ge_k;
      C_CMD_LEN:   taken = status_i.cmd_len;
      C_CMD_END:   taken = status_i.cmd_end;
      C_FULL:      taken = status_i.full;
      C_NOT_FULL:  taken = !status_i.full;
      C_EMIT_BUSY: taken = !status_i.last_fire;
      default:     taken = 1'b1;
    endcase
    step_d = taken ? ctrl.target : step_q + step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StWait;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

### rtl/flwe_datapath.sv
module flwe_datapath
  import flwe_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ctrl_t          ctrl_i,
  output status_t        status_o,
  flwe_cfg_if.sink       cfg_i,
  flwe_in_if.sink        in_i,
  flwe_out_if.source     out_o
);

  logic [CfgW-1:0] win_size_q;
  cmd_e            cmd_q;
  len_t            len_q;
  len_t            ring_len_q [MaxWindow];
  logic            ring_flag_q [MaxWindow];
  idx_t            oldest_q;
  cnt_t            fill_q;
  logic            full_q;
  logic            region_q;
  logic [OffW-1:0] shift_q;
  idx_t            slot_q;
  idx_t            pos_q;

  cnt_t            k_eff;
  cnt_t            oldest_ext;
  cnt_t            fill_inc;
  cnt_t            oldest_inc;
  cnt_t            slot_inc;
  idx_t            rd_addr;
  len_t            rd_len;
  logic [OffW:0]   shift_sum;
  logic            in_fire;
  logic            out_fire;
  logic            is_last;

  always_comb begin
    if (win_size_q == '0) begin
      k_eff = cnt_t'(1);
    end else if (32'(win_size_q) > MaxWindow) begin
      k_eff = cnt_t'(MaxWindow);
    end else begin
      k_eff = cnt_t'(win_size_q);
    end
  end

  assign oldest_ext = cnt_t'(oldest_q);
  assign fill_inc   = fill_q + cnt_t'(1);
  assign oldest_inc = oldest_ext + cnt_t'(1);
  assign slot_inc   = cnt_t'(slot_q) + cnt_t'(1);
  assign rd_addr    = (ctrl_i.op == OP_SLIDE) ? oldest_q : slot_q;
  assign rd_len     = ring_len_q[rd_addr];
  assign shift_sum  = {1'b0, shift_q} + (OffW + 1)'(rd_len);
  assign is_last    = (cnt_t'(pos_q) == k_eff - cnt_t'(1));

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (ctrl_i.op == OP_LATCH);
  assign in_fire     = in_i.valid && in_i.ready;

  assign out_o.valid          = (ctrl_i.op == OP_EMIT);
  assign out_o.element_length = rd_len;
  assign out_o.second_pass    = ring_flag_q[slot_q];
  assign out_o.window_offset  = shift_q;
  assign out_o.last_of_window = is_last;
  assign out_fire             = out_o.valid && out_o.ready;

  assign status_o.in_fire   = in_fire;
  assign status_o.last_fire = out_fire && is_last;
  assign status_o.old_ge_k  = (oldest_ext >= k_eff);
  assign status_o.cmd_len   = (cmd_q == CMD_LEN);
  assign status_o.cmd_end   = (cmd_q == CMD_END);
  assign status_o.full      = full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= WinSizeReset;
      cmd_q      <= CMD_LEN;
      len_q      <= '0;
      oldest_q   <= '0;
      fill_q     <= '0;
      full_q     <= 1'b0;
      region_q   <= 1'b0;
      shift_q    <= '0;
      slot_q     <= '0;
      pos_q      <= '0;
      for (int i = 0; i < MaxWindow; i++) begin
        ring_len_q[i]  <= '0;
        ring_flag_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_i.valid) begin
        win_size_q <= cfg_i.window_size;
      end
      case (ctrl_i.op)
        OP_LATCH: begin
          if (in_fire) begin
            cmd_q <= cmd_e'(in_i.cmd);
            len_q <= in_i.factor_length;
          end
        end
        OP_REDUCE: begin
          if (oldest_ext >= k_eff) begin
            oldest_q <= idx_t'(oldest_ext - k_eff);
          end
        end
        OP_SET_REGION: region_q <= (cmd_q == CMD_SET);
        OP_ZERO_OLDEST: oldest_q <= '0;
        OP_PROMOTE: begin
          if (!full_q && fill_q >= k_eff) begin
            full_q   <= 1'b1;
            oldest_q <= '0;
          end
        end
        OP_FILL: begin
          ring_len_q[idx_t'(fill_q)]  <= len_q;
          ring_flag_q[idx_t'(fill_q)] <= region_q;
          fill_q <= fill_inc;
          if (fill_inc >= k_eff) begin
            full_q   <= 1'b1;
            oldest_q <= '0;
          end
        end
        OP_SLIDE: begin
          shift_q <= shift_sum[OffW] ? OffMax : shift_sum[OffW-1:0];
          ring_len_q[oldest_q]  <= len_q;
          ring_flag_q[oldest_q] <= region_q;
          oldest_q <= (oldest_inc == k_eff) ? '0 : idx_t'(oldest_inc);
        end
        OP_EMIT_INIT: begin
          slot_q <= oldest_q;
          pos_q  <= '0;
        end
        OP_EMIT: begin
          if (out_fire) begin
            slot_q <= (slot_inc == k_eff) ? '0 : idx_t'(slot_inc);
            pos_q  <= pos_q + idx_t'(1);
          end
        end
        OP_CLEAR: begin
          oldest_q <= '0;
          fill_q   <= '0;
          full_q   <= 1'b0;
          region_q <= 1'b0;
          shift_q  <= '0;
          for (int i = 0; i < MaxWindow; i++) begin
            ring_len_q[i]  <= '0;
            ring_flag_q[i] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/factor_length_window_emitter.sv
// Factor length window emitter.
// in_i takes one word per command: cmd 0 carries a factor length, 1 and 2 open
// and close a refactorized region, 3 ends the read. out_o gives the window
// oldest-first, one word per entry, last_of_window on the final one. cfg_i sets
// window_size (K); write it only while the block is idle. cfg_i is always ready.
// One word is handled at a time by a microcoded sequencer: in_i.ready is high
// only while it waits for a word. A length that slides the window, one that
// fills it and the end of a read whose window never filled each show the
// window after acceptance: K words at one per cycle while out_o.ready stays
// high; in_i is then ready again, after the ring is cleared for end of read.
// A length that does not complete the window, the region markers and an end
// of read after a full window give no words. After a change of window_size
// the first word may be delayed while the ring pointer is brought below K by
// repeated subtraction.
// A stalled out_o holds its word and the sequencer waits on that step.
// Reset sets K to 4 and clears the ring, counters and region flag.
module factor_length_window_emitter
  import flwe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  flwe_cfg_if.sink   cfg_i,
  flwe_in_if.sink    in_i,
  flwe_out_if.source out_o
);

  ctrl_t   ctrl;
  status_t status;

  flwe_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  flwe_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .status_o (status),
    .cfg_i    (cfg_i),
    .in_i     (in_i),
    .out_o    (out_o)
  );

endmodule

### rtl/flwe_checker.sv
module flwe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_last_i
);

  // one word in flight: no input taken while a result is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && in_ready_i))
    else $error("input ready while output valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after accept");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !out_last_i) |=> out_valid_i)
    else $error("window words not contiguous");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> !out_valid_i)
    else $error("word after last of window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output valid dropped while stalled");

endmodule

bind factor_length_window_emitter flwe_checker u_flwe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_last_i  (out_o.last_of_window)
);
